[design/three_axis_moving_average_min_max_top_macros.svh]
// assertion macros shared by the moving average block
`ifndef THREE_AXIS_MOVING_AVERAGE_MIN_MAX_TOP_MACROS_SVH
`define THREE_AXIS_MOVING_AVERAGE_MIN_MAX_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define TAMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define TAMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tamm_pkg.sv]
// shared constants for the three-axis moving average block
`timescale 1ns / 1ps

package tamm_pkg;

  // sample and result element width
  localparam int SampleW = 16;
  // number of axes handled side by side
  localparam int Axes = 3;
  // default averaging window length
  localparam int DefaultWindowLen = 10;
  // entries in the sum queue between front and back
  localparam int QueueDepth = 4;

  // front/back queue status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/tamm_front.sv]
// front end: sample windows and running sums per axis
`timescale 1ns / 1ps

module tamm_front #(
  parameter int WINDOW_LEN = tamm_pkg::DefaultWindowLen,
  parameter int SumW = tamm_pkg::SampleW + $clog2(WINDOW_LEN)
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  output logic                                            ready_o,
  input  logic [tamm_pkg::Axes-1:0][tamm_pkg::SampleW-1:0] sample_i,
  input  tamm_pkg::queue_status_t                         queue_i,
  output logic                                            push_o,
  output logic [tamm_pkg::Axes-1:0][SumW-1:0]             sum_o
);

  localparam int SampleW = tamm_pkg::SampleW;
  localparam int Axes = tamm_pkg::Axes;

  logic [SampleW-1:0] win_q [Axes][WINDOW_LEN];
  logic [Axes-1:0][SumW-1:0] sum_q, sum_d;
  logic accept;

  // take a request whenever the queue has room
  assign ready_o = !queue_i.full;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept;
  assign sum_o   = sum_d;

  // running sum: add newest sample, drop oldest window entry
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      sum_d[a] = sum_q[a]
               - {{(SumW-SampleW){win_q[a][0][SampleW-1]}}, win_q[a][0]}
               + {{(SumW-SampleW){sample_i[a][SampleW-1]}}, sample_i[a]};
    end
  end

  // window shift line and sum registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < Axes; a++) begin
        sum_q[a] <= '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_q[a][i] <= '0;
        end
      end
    end else if (accept) begin
      for (int a = 0; a < Axes; a++) begin
        sum_q[a] <= sum_d[a];
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_q[a][i] <= win_q[a][i+1];
        end
        win_q[a][WINDOW_LEN-1] <= sample_i[a];
      end
    end
  end

endmodule

[design/tamm_queue.sv]
// short fifo carrying window sums from front to back
`timescale 1ns / 1ps

module tamm_queue #(
  parameter int DataW = 60,
  parameter int Depth = tamm_pkg::QueueDepth,
  parameter int LvlW = $clog2(Depth + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [DataW-1:0]        data_i,
  input  logic                    pop_i,
  output logic [DataW-1:0]        data_o,
  output tamm_pkg::queue_status_t status_o,
  output logic [LvlW-1:0]         level_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0] count_q;

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == LvlW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign level_o        = count_q;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[design/tamm_back.sv]
// back end: divide sums by window length, track extremes, output register
`timescale 1ns / 1ps

module tamm_back #(
  parameter int WINDOW_LEN = tamm_pkg::DefaultWindowLen,
  parameter int SumW = tamm_pkg::SampleW + $clog2(WINDOW_LEN)
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [tamm_pkg::Axes-1:0][SumW-1:0]              sum_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [tamm_pkg::Axes-1:0][tamm_pkg::SampleW-1:0] avg_o,
  output logic [tamm_pkg::Axes-1:0][tamm_pkg::SampleW-1:0] min_o,
  output logic [tamm_pkg::Axes-1:0][tamm_pkg::SampleW-1:0] max_o
);

  localparam int SampleW = tamm_pkg::SampleW;
  localparam int Axes = tamm_pkg::Axes;
  localparam int ShiftW = SumW + $clog2(WINDOW_LEN);
  localparam int RecipW = SumW + 1;
  localparam int ProdW = SumW + RecipW;
  localparam int QuotW = SampleW + 1;
  // ceil(2^ShiftW / WINDOW_LEN), exact quotient for any SumW-bit magnitude
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << ShiftW) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [Axes-1:0][ProdW-1:0] prod_q, prod_d;
  logic [Axes-1:0] neg_q;
  logic a_valid_q, out_valid_q;
  logic a_ready, out_ready, a_load, out_load;
  logic [Axes-1:0][SampleW-1:0] avg_q, avg_d, min_q, max_q, min_d, max_d;

  // handshake chain through both stages
  assign out_ready = !out_valid_q || ready_i;
  assign a_ready   = !a_valid_q || out_ready;
  assign a_load    = valid_i && a_ready;
  assign out_load  = a_valid_q && out_ready;
  assign ready_o   = a_ready;
  assign valid_o   = out_valid_q;

  // stage a: magnitude times reciprocal
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      logic [SumW-1:0] mag;
      mag = sum_i[a][SumW-1] ? (~sum_i[a] + 1'b1) : sum_i[a];
      prod_d[a] = ProdW'(mag) * ProdW'(Recip);
    end
  end

  // stage b: restore sign, update extremes
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      logic [QuotW-1:0] quot;
      quot = prod_q[a][ShiftW +: QuotW];
      avg_d[a] = SampleW'(neg_q[a] ? (~quot + 1'b1) : quot);
      min_d[a] = ($signed(avg_d[a]) < $signed(min_q[a])) ? avg_d[a] : min_q[a];
      max_d[a] = ($signed(avg_d[a]) > $signed(max_q[a])) ? avg_d[a] : max_q[a];
    end
  end

  // stage a payload
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      prod_q <= prod_d;
      for (int a = 0; a < Axes; a++) begin
        neg_q[a] <= sum_i[a][SumW-1];
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q <= avg_d;
    end
  end

  // valid flags and running extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= '0;
      max_q       <= '0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= a_valid_q;
      end
      if (out_load) begin
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

  assign avg_o = avg_q;
  assign min_o = min_q;
  assign max_o = max_q;

endmodule

[design/three_axis_moving_average_min_max_top.sv]
// top level of the three-axis moving average with running min and max
// Usage:
//   s_axis carries one request per sample: x, y, z as signed 16-bit values.
//   m_axis carries one result per sample: the three window averages
//   (truncated toward zero) and the running minimum and maximum of each.
//   A sample accepted on s_axis passes through the sum queue, the back's
//   stage a register and its output register before it shows on m_axis.
//   Throughput is one sample per cycle unless the queue is full or m_axis
//   stalls: the front keeps running sums in a window shift line, the back
//   divides by a constant reciprocal multiply and compares against the extremes.
//   A four-entry queue sits between front and back; s_axis_tready_o
//   drops only when that queue is full.
//   When the receiver stalls, the result holds on m_axis and the two
//   back stages plus the queue keep absorbing samples until full.
//   Reset clears windows, sums and extremes to zero and empties the
//   pipeline; the first WINDOW_LEN - 1 averages include the zero entries.
`timescale 1ns / 1ps
`include "three_axis_moving_average_min_max_top_macros.svh"

module three_axis_moving_average_min_max_top #(
  parameter int WINDOW_LEN = tamm_pkg::DefaultWindowLen
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sample_x [15:0], sample_y [31:16], sample_z [47:32]
  input  logic [47:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // avg_x, avg_y, avg_z, min_x, min_y, min_z, max_x, max_y, max_z, 16 bits each
  output logic [143:0] m_axis_tdata_o
);

  localparam int SampleW = tamm_pkg::SampleW;
  localparam int Axes = tamm_pkg::Axes;
  localparam int SumW = SampleW + $clog2(WINDOW_LEN);
  localparam int Depth = tamm_pkg::QueueDepth;
  localparam int LvlW = $clog2(Depth + 1);

  logic [Axes-1:0][SampleW-1:0] sample;
  logic [Axes-1:0][SumW-1:0] front_sum, back_sum;
  logic [Axes-1:0][SampleW-1:0] avg, min_v, max_v;
  tamm_pkg::queue_status_t q_status;
  logic [LvlW-1:0] q_level;
  logic push, pop, back_ready;

  assign sample = s_axis_tdata_i;

  // sample windows and running sums
  tamm_front #(
    .WINDOW_LEN(WINDOW_LEN),
    .SumW      (SumW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .sample_i(sample),
    .queue_i (q_status),
    .push_o  (push),
    .sum_o   (front_sum)
  );

  // sum queue
  tamm_queue #(
    .DataW(Axes * SumW),
    .Depth(Depth),
    .LvlW (LvlW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_sum),
    .pop_i   (pop),
    .data_o  (back_sum),
    .status_o(q_status),
    .level_o (q_level)
  );

  assign pop = !q_status.empty && back_ready;

  // divide and extremes
  tamm_back #(
    .WINDOW_LEN(WINDOW_LEN),
    .SumW      (SumW)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(!q_status.empty),
    .ready_o(back_ready),
    .sum_i  (back_sum),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .avg_o  (avg),
    .min_o  (min_v),
    .max_o  (max_v)
  );

  assign m_axis_tdata_o = {max_v, min_v, avg};

  // checks
  `TAMM_ASSERT_NOW(a_level_bound, 1'b1, q_level <= LvlW'(Depth), "sum queue overfilled")
  `TAMM_ASSERT_NEXT(a_push_lands, s_axis_tvalid_i && s_axis_tready_o, q_level != '0,
    "accepted sample missing from queue")
  `TAMM_ASSERT_NOW(a_avg_in_range, m_axis_tvalid_o,
    $signed(min_v[0]) <= $signed(avg[0]) && $signed(avg[0]) <= $signed(max_v[0]) &&
    $signed(min_v[1]) <= $signed(avg[1]) && $signed(avg[1]) <= $signed(max_v[1]) &&
    $signed(min_v[2]) <= $signed(avg[2]) && $signed(avg[2]) <= $signed(max_v[2]),
    "average outside running extremes")

endmodule

[tb/three_axis_moving_average_min_max_checker.sv]
// result checker for the three-axis moving average block: predicts each result and compares
`timescale 1ns / 1ps

module three_axis_moving_average_min_max_checker #(
  parameter int WINDOW_LEN = tamm_pkg::DefaultWindowLen
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // sample_x, sample_y, sample_z, 16 bits each
  input  logic [47:0]  s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // avg_x, avg_y, avg_z, min_x, min_y, min_z, max_x, max_y, max_z, 16 bits each
  input  logic [143:0] m_axis_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int SampleW = tamm_pkg::SampleW;
  localparam int Axes = tamm_pkg::Axes;
  localparam int Fields = 3 * Axes;
  localparam int MaxReports = 10;

  typedef logic signed [SampleW-1:0] axis_val_t;

  string field_name [Fields] = '{"avg_x", "avg_y", "avg_z", "min_x", "min_y", "min_z",
                                 "max_x", "max_y", "max_z"};

  // predicted block state
  axis_val_t win_hist [Axes][WINDOW_LEN];
  axis_val_t avg_min [Axes];
  axis_val_t avg_max [Axes];

  // results expected on the output side, oldest first
  logic [Fields*SampleW-1:0] expected_avg_q [$];
  int mismatch_count;

  // shift one request into the windows, average, update extremes
  function automatic logic [Fields*SampleW-1:0] predict_averages(logic [Axes*SampleW-1:0] req);
    logic [Fields*SampleW-1:0] res;
    int sum;
    axis_val_t avg;
    res = '0;
    for (int a = 0; a < Axes; a++) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_hist[a][i] = win_hist[a][i+1];
      end
      win_hist[a][WINDOW_LEN-1] = axis_val_t'(req[a*SampleW +: SampleW]);
      sum = 0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        sum += int'(win_hist[a][i]);
      end
      // signed int division truncates toward zero
      avg = axis_val_t'(sum / WINDOW_LEN);
      if (avg < avg_min[a]) avg_min[a] = avg;
      if (avg > avg_max[a]) avg_max[a] = avg;
      res[a*SampleW +: SampleW] = avg;
      res[(Axes+a)*SampleW +: SampleW] = avg_min[a];
      res[(2*Axes+a)*SampleW +: SampleW] = avg_max[a];
    end
    return res;
  endfunction

  // count a failure, print the first few
  task automatic note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: result mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    logic [Fields*SampleW-1:0] want;
    if (!rst_ni) begin
      for (int a = 0; a < Axes; a++) begin
        for (int i = 0; i < WINDOW_LEN; i++) win_hist[a][i] = '0;
        avg_min[a] = '0;
        avg_max[a] = '0;
      end
      expected_avg_q.delete();
      mismatch_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results leave before a new request is predicted
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_avg_q.size() == 0) begin
          note_mismatch("unexpected result avg_x", 0,
                        int'(axis_val_t'(m_axis_tdata_i[SampleW-1:0])));
        end else begin
          want = expected_avg_q.pop_front();
          for (int f = 0; f < Fields; f++) begin
            if (m_axis_tdata_i[f*SampleW +: SampleW] !== want[f*SampleW +: SampleW]) begin
              note_mismatch(field_name[f], int'(axis_val_t'(want[f*SampleW +: SampleW])),
                            int'(axis_val_t'(m_axis_tdata_i[f*SampleW +: SampleW])));
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_avg_q.push_back(predict_averages(s_axis_tdata_i));
      end
      fail_count_o <= mismatch_count;
      pending_o <= expected_avg_q.size();
    end
  end

endmodule

[tb/three_axis_moving_average_min_max_top_tb.sv]
// stimulus, flow control and verdict for the three-axis moving average block
`timescale 1ns / 1ps

module three_axis_moving_average_min_max_top_tb;

  localparam int WindowLen = tamm_pkg::DefaultWindowLen;
  localparam int ClkPeriod = 20;
  localparam int ResetCycles = 12;
  localparam int RandomItems = 1300;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 12;
  localparam int LongHold = 60;
  localparam int FirstHoldAt = 150;
  localparam int HoldSpacing = 500;

  typedef enum int {
    VAL_ANY,
    VAL_NEAR_ZERO,
    VAL_POSITIVE,
    VAL_NEGATIVE,
    VAL_RAILS
  } value_kind_e;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  int           fail_count;
  int           pending;

  int samples_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  three_axis_moving_average_min_max_top #(
    .WINDOW_LEN(WindowLen)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  three_axis_moving_average_min_max_checker #(
    .WINDOW_LEN(WindowLen)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // reset once at the start
  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
  end

  // end the run when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("three_axis_moving_average_min_max_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request, in bursts separated by random gaps
  task automatic offer_request(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // one axis value of the given flavor
  function automatic logic [15:0] random_axis(value_kind_e kind);
    case (kind)
      VAL_NEAR_ZERO: return 16'($urandom_range(0, 40)) - 16'd20;
      VAL_POSITIVE:  return 16'h4000 + 16'($urandom_range(0, 16383));
      VAL_NEGATIVE:  return 16'h8000 + 16'($urandom_range(0, 16383));
      VAL_RAILS: begin
        if ($urandom_range(0, 1) == 1) return 16'h7fff - 16'($urandom_range(0, 3));
        return 16'h8000 + 16'($urandom_range(0, 3));
      end
      default:       return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall patterns plus a few long hold-offs
  initial begin
    int span;
    int mode;
    int next_hold;
    next_hold = FirstHoldAt;
    while (!rst_n) @(posedge clk);
    forever begin
      if (samples_sent >= next_hold) begin
        // hold off long enough to fill the block and stall its input
        next_hold += HoldSpacing;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        span = $urandom_range(8, 64);
        mode = $urandom_range(0, 3);
        for (int i = 0; i < span; i++) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    value_kind_e kind [3];
    int seg_left;
    seg_left = 0;
    while (!rst_n) @(posedge clk);

    // warm-up with zeros in the window, small values truncating toward zero
    offer_request(16'hfff7, 16'h0009, 16'hffff);
    offer_request(16'h0001, 16'hffff, 16'h0000);
    offer_request(16'h0000, 16'h0000, 16'h0000);
    // x climbs to the top rail, y to the bottom, z alternates rails
    for (int i = 0; i < 10; i++) begin
      offer_request(16'h7fff, 16'h8000, (i % 2 == 0) ? 16'h7fff : 16'h8000);
    end
    // then the other way round
    for (int i = 0; i < 10; i++) begin
      offer_request(16'h8000, 16'h7fff, (i % 2 == 0) ? 16'h8000 : 16'h7fff);
    end

    // random segments, each axis with its own value flavor
    for (int n = 0; n < RandomItems; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 40);
        for (int a = 0; a < 3; a++) kind[a] = value_kind_e'($urandom_range(0, 4));
      end
      seg_left--;
      offer_request(random_axis(kind[0]), random_axis(kind[1]), random_axis(kind[2]));
    end
    s_tvalid <= 1'b0;

    // wait until the count includes the last request and every result is back
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("three_axis_moving_average_min_max_top: match");
    end else begin
      $display("three_axis_moving_average_min_max_top: mismatch");
    end
    $finish;
  end

endmodule
